// ----- rtl/grpe_pkg.sv -----
// ----------------------------------------------------------------------------
// grpe_pkg: shared types and constants of the glyph row pixel expander
// Holds the sequencer states, the adder operation codes, the register index
// codes and the fixed Cyrillic recoding table.
// ----------------------------------------------------------------------------
package grpe_pkg;

  // Raw font addresses never exceed 255*63+31, so fourteen bits hold them all.
  localparam int RAW_W    = 14;
  localparam int RAW_SPAN = 16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_OFFSET,
    ST_MOD,
    ST_WRITE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [RAW_W-1:0] res;
    logic             borrow;
  } alu_res_t;

  typedef enum logic [2:0] {
    CFG_FOREGROUND = 3'd0,
    CFG_BACKGROUND = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_WIDTH      = 3'd3,
    CFG_COL_MAJOR  = 3'd4
  } cfg_index_t;

  localparam logic [7:0] CYR_MAP [128] = '{
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
    8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
    8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h20,8'h21,8'hDD,8'h23,8'h24,8'h25,8'h3F,8'hFD,
    8'h28,8'h29,8'h2A,8'h2B,8'hE1,8'h2D,8'hFE,8'h2E,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'hC6,8'hE6,8'hC1,8'h3D,8'hDE,8'h2C,
    8'h22,8'hD4,8'hC8,8'hD1,8'hC2,8'hD3,8'hC0,8'hCF,
    8'hD0,8'hD8,8'hCE,8'hCB,8'hC4,8'hDC,8'hD2,8'hD9,
    8'hC7,8'hC9,8'hCA,8'hDB,8'hC5,8'hC3,8'hCC,8'hD6,
    8'hD7,8'hCD,8'hDF,8'hF5,8'h5C,8'hFA,8'h3A,8'h5F,
    8'hB8,8'hF4,8'hE8,8'hF1,8'hE2,8'hF3,8'hE0,8'hEF,
    8'hF0,8'hF8,8'hEE,8'hEB,8'hE4,8'hFC,8'hF2,8'hF9,
    8'hE7,8'hE9,8'hEA,8'hFB,8'hE5,8'hE3,8'hEC,8'hF6,
    8'hF7,8'hED,8'hFF,8'hD5,8'h7C,8'hDA,8'hA8,8'h00
  };

endpackage

// ----- rtl/grpe_alu.sv -----
// ----------------------------------------------------------------------------
// grpe_alu: shared add/subtract unit
// One adder serves the shift-add multiply, the offset add, the modulo
// reduction and the per-column address decrement.
// ----------------------------------------------------------------------------
module grpe_alu
  import grpe_pkg::*;
(
  input  alu_op_t          op,
  input  logic [RAW_W-1:0] a,
  input  logic [RAW_W-1:0] b,
  output alu_res_t         result
);

  logic [RAW_W:0]   sum;
  logic [RAW_W-1:0] b_in;

  assign b_in = (op == ALU_SUB) ? ~b : b;
  // A subtraction is a plus the inverted b plus one; no carry out means a < b.
  assign sum  = {1'b0, a} + {1'b0, b_in} + {{RAW_W{1'b0}}, (op == ALU_SUB)};

  assign result.res    = sum[RAW_W-1:0];
  assign result.borrow = (op == ALU_SUB) && !sum[RAW_W];

endmodule

// ----- rtl/grpe_font_mem.sv -----
// ----------------------------------------------------------------------------
// grpe_font_mem: font word store
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module grpe_font_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/glyph_row_pixel_expander.sv -----
// ----------------------------------------------------------------------------
// glyph_row_pixel_expander: bitmap font character generator
// Loads 16-bit font words into an internal store and expands one glyph row
// into a stream of foreground/background pixels, last pixel flagged.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                      Transaction when
// -------   -------------------------------------------  ----------------------
// item      start, busy, mode, word_address, word_data,  start high, busy low
//           glyph_code, row_index, remap
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid and cfg_ready
// pixel     pixel_valid, pixel_color, last               pixel_valid high
//
// A load passes from its transaction through S modulo reduction steps for
// FONT_WORDS (S = clog2(ceil(16384 / FONT_WORDS)), zero for a store of
// 16384 words or more) to the store write. A draw passes through the
// six-step shift-add multiply on the single shared adder, the offset add,
// the S modulo steps and the RAM read, and then emits one pixel per cycle
// from the one RAM read port.
// Rows at or beyond the glyph height, and a zero width, finish at once.
// Reset clears the sequencer and the registers; the font store is not
// cleared and must be loaded before it is drawn from.
// Pixels cannot be stalled: each one stands on the ports for one cycle.
//
// Sequence: the adder forms code*height+row (or code*width+width-1) one
// multiplier bit a cycle, then takes the address modulo FONT_WORDS by
// conditional subtraction of FONT_WORDS shifted left, largest shift first.
// In column-major mode each pixel needs its own word, so the read address
// steps down by one each cycle, wrapping to FONT_WORDS-1 below zero, and the
// RAM is read one column ahead of the pixel being emitted.
// ----------------------------------------------------------------------------
module glyph_row_pixel_expander
  import grpe_pkg::*;
#(
  parameter int FONT_WORDS = 8192,
  parameter int MAX_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [12:0] word_address,
  input  logic [15:0] word_data,
  input  logic [7:0]  glyph_code,
  input  logic [4:0]  row_index,
  input  logic        remap,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // pixel channel
  output logic        pixel_valid,
  output logic [15:0] pixel_color,
  output logic        last
);

  localparam int AW        = $clog2(FONT_WORDS);
  localparam int MOD_STEPS = $clog2((RAW_SPAN + FONT_WORDS - 1) / FONT_WORDS);
  localparam logic [2:0] MOD_TOP = (MOD_STEPS > 0) ? 3'(MOD_STEPS - 1) : 3'd0;
  localparam logic [RAW_W-1:0] MOD_BASE = RAW_W'(FONT_WORDS);
  localparam int WRAP_INT  = (FONT_WORDS < RAW_SPAN) ? FONT_WORDS - 1 : RAW_SPAN - 1;
  localparam logic [RAW_W-1:0] WRAP_ADDR = RAW_W'(WRAP_INT);
  localparam logic [4:0] WIDTH_CAP = 5'(MAX_WIDTH);

  // Configuration registers.
  logic [15:0] foreground_color;
  logic [15:0] background_color;
  logic [5:0]  glyph_height;
  logic [4:0]  glyph_width;
  logic        column_major;

  // Sequencer and datapath registers.
  state_t           state, state_next;
  logic [RAW_W-1:0] acc, acc_next;
  logic [2:0]       step, step_next;
  logic [3:0]       col, col_next;
  logic             mode_q, mode_q_next;
  logic [7:0]       code_q, code_q_next;
  logic [4:0]       row_q, row_q_next;
  logic [5:0]       mult_q, mult_q_next;
  logic [4:0]       offset_q, offset_q_next;
  logic [15:0]      data_q, data_q_next;
  logic             pixel_valid_next;
  logic [15:0]      pixel_color_next;
  logic             last_next;

  // Shared adder.
  alu_op_t          alu_op;
  logic [RAW_W-1:0] alu_a, alu_b;
  alu_res_t         alu_out;
  logic [RAW_W-1:0] addr_dec;

  // Font store.
  logic             mem_wr_en, mem_rd_en;
  logic [15:0]      rd_data;

  logic [4:0]       width_eff;
  logic [7:0]       code_mapped;
  logic             pixel_on;

  assign width_eff = (glyph_width > WIDTH_CAP) ? WIDTH_CAP : glyph_width;
  assign code_mapped = (remap && !glyph_code[7]) ? CYR_MAP[glyph_code[6:0]] : glyph_code;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Address one below the current one, modulo the store size.
  assign addr_dec = (acc == '0) ? WRAP_ADDR : alu_out.res;

  grpe_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_out)
  );

  grpe_font_mem #(
    .DEPTH (FONT_WORDS),
    .AW    (AW)
  ) u_font_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(acc)),
    .wr_data (data_q),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(acc)),
    .rd_data (rd_data)
  );

  // Adder operand selection for the current step.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = acc;
    alu_b  = '0;
    unique case (state)
      ST_MUL: begin
        alu_a = {acc[RAW_W-2:0], 1'b0};
        alu_b = mult_q[step] ? RAW_W'(code_q) : '0;
      end
      ST_OFFSET: begin
        alu_b = RAW_W'(offset_q);
      end
      ST_MOD: begin
        alu_op = ALU_SUB;
        alu_b  = MOD_BASE << step;
      end
      ST_READ, ST_EMIT: begin
        alu_op = ALU_SUB;
        alu_b  = RAW_W'(1);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Pixel bit selection. The bit index is 16 minus the column (row-major) or
  // 16 minus the row (column-major); an index of 16 or below zero is off.
  always_comb begin
    if (!column_major) begin
      pixel_on = (col != 4'd0) && rd_data[4'(5'd16 - {1'b0, col})];
    end else begin
      pixel_on = (row_q != 5'd0) && (row_q <= 5'd16) && rd_data[4'(5'd16 - row_q)];
    end
  end

  // Sequencer.
  always_comb begin
    state_next       = state;
    acc_next         = acc;
    step_next        = step;
    col_next         = col;
    mode_q_next      = mode_q;
    code_q_next      = code_q;
    row_q_next       = row_q;
    mult_q_next      = mult_q;
    offset_q_next    = offset_q;
    data_q_next      = data_q;
    mem_wr_en        = 1'b0;
    mem_rd_en        = 1'b0;
    pixel_valid_next = 1'b0;
    pixel_color_next = pixel_color;
    last_next        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_q_next = mode;
          code_q_next = code_mapped;
          row_q_next  = row_index;
          data_q_next = word_data;
          if (!mode) begin
            acc_next  = RAW_W'(word_address);
            step_next = MOD_TOP;
            state_next = (MOD_STEPS > 0) ? ST_MOD : ST_WRITE;
          end else if (({1'b0, row_index} < glyph_height) && (width_eff != 5'd0)) begin
            acc_next      = '0;
            step_next     = 3'd5;
            mult_q_next   = column_major ? {1'b0, width_eff} : glyph_height;
            offset_q_next = column_major ? (width_eff - 5'd1) : row_index;
            state_next    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_next = alu_out.res;
        if (step == 3'd0) begin
          state_next = ST_OFFSET;
        end else begin
          step_next = step - 3'd1;
        end
      end
      ST_OFFSET: begin
        acc_next   = alu_out.res;
        step_next  = MOD_TOP;
        state_next = (MOD_STEPS > 0) ? ST_MOD : ST_READ;
      end
      ST_MOD: begin
        if (!alu_out.borrow) begin
          acc_next = alu_out.res;
        end
        if (step == 3'd0) begin
          state_next = mode_q ? ST_READ : ST_WRITE;
        end else begin
          step_next = step - 3'd1;
        end
      end
      ST_WRITE: begin
        mem_wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        mem_rd_en  = 1'b1;
        acc_next   = addr_dec;
        col_next   = 4'd0;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        pixel_valid_next = 1'b1;
        pixel_color_next = pixel_on ? foreground_color : background_color;
        if (column_major) begin
          // Fetch the next column's word while this one is shown.
          mem_rd_en = 1'b1;
          acc_next  = addr_dec;
        end
        if (({1'b0, col} + 5'd1) == width_eff) begin
          last_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          col_next = col + 4'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pixel_valid <= 1'b0;
    end else begin
      state       <= state_next;
      pixel_valid <= pixel_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc         <= acc_next;
    step        <= step_next;
    col         <= col_next;
    mode_q      <= mode_q_next;
    code_q      <= code_q_next;
    row_q       <= row_q_next;
    mult_q      <= mult_q_next;
    offset_q    <= offset_q_next;
    data_q      <= data_q_next;
    pixel_color <= pixel_color_next;
    last        <= last_next;
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      foreground_color <= 16'hFFFF;
      background_color <= 16'h0000;
      glyph_height     <= 6'd22;
      glyph_width      <= 5'd14;
      column_major     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FOREGROUND: foreground_color <= cfg_data;
        CFG_BACKGROUND: background_color <= cfg_data;
        CFG_HEIGHT:     glyph_height     <= cfg_data[5:0];
        CFG_WIDTH:      glyph_width      <= cfg_data[4:0];
        CFG_COL_MAJOR:  column_major     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every pixel comes from a cycle spent in the emit state.
  a_pixel_from_emit: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> $past(state == ST_EMIT))
    else $error("pixel strobe without an emit cycle");

  // The block is free again while the last pixel of a row is shown, and no
  // pixel follows it directly; a new transaction may already be under way.
  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && last |-> !busy ##1 !pixel_valid)
    else $error("busy or another pixel at the end of a row");

  // A font store write finishes a load and produces no pixel.
  a_write_no_pixel: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> !pixel_valid && !busy)
    else $error("load produced a pixel or stayed busy");
`endif

endmodule
